// ===== design/sbi_pkg.sv =====
// Package: payload types and constants for the segment/box intersection block.
`timescale 1ns / 1ps
package sbi_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned NumFaces = 6;

  typedef struct packed {
    logic signed [CoordW-1:0] box_min_x;
    logic signed [CoordW-1:0] box_min_y;
    logic signed [CoordW-1:0] box_min_z;
    logic signed [CoordW-1:0] box_max_x;
    logic signed [CoordW-1:0] box_max_y;
    logic signed [CoordW-1:0] box_max_z;
    logic signed [CoordW-1:0] seg_start_x;
    logic signed [CoordW-1:0] seg_start_y;
    logic signed [CoordW-1:0] seg_start_z;
    logic signed [CoordW-1:0] seg_end_x;
    logic signed [CoordW-1:0] seg_end_y;
    logic signed [CoordW-1:0] seg_end_z;
  } sbi_query_t;

  typedef struct packed {
    logic                     hit_found;
    logic signed [CoordW-1:0] hit_x;
    logic signed [CoordW-1:0] hit_y;
    logic signed [CoordW-1:0] hit_z;
  } sbi_result_t;

endpackage

// ===== design/sbi_divider.sv =====
// Pipelined restoring divider: quotient of num / den, one quotient bit per stage.
`timescale 1ns / 1ps
module sbi_divider import sbi_pkg::*; #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned DenW     = 33,
  parameter int unsigned TagW     = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [DenW-1:0]     num_i,
  input  logic [DenW-1:0]     den_i,
  input  logic [TagW-1:0]     tag_i,
  output logic                valid_o,
  output logic [FracBits-1:0] quot_o,
  output logic [TagW-1:0]     tag_o
);
  // The caller must keep num < den (not enforced here), so that the quotient of (num << FracBits)/den is FracBits wide.
  localparam int unsigned Stages = FracBits;

  // element s holds the output of stage s
  logic                vld_q [Stages];
  logic [DenW-1:0]     rem_q [Stages];
  logic [DenW-1:0]     den_q [Stages];
  logic [FracBits-1:0] quo_q [Stages];
  logic [TagW-1:0]     tag_q [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic                vld_s;
    logic [DenW-1:0]     rem_s;
    logic [DenW-1:0]     den_s;
    logic [FracBits-1:0] quo_s;
    logic [TagW-1:0]     tag_s;
    logic [DenW:0]       trial;
    logic                ge;

    if (s == 0) begin : g_head
      assign vld_s = valid_i;
      assign rem_s = num_i;
      assign den_s = den_i;
      assign quo_s = '0;
      assign tag_s = tag_i;
    end else begin : g_body
      assign vld_s = vld_q[s-1];
      assign rem_s = rem_q[s-1];
      assign den_s = den_q[s-1];
      assign quo_s = quo_q[s-1];
      assign tag_s = tag_q[s-1];
    end

    assign trial = {rem_s, 1'b0};
    assign ge    = trial >= {1'b0, den_s};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? DenW'(trial - {1'b0, den_s}) : DenW'(trial);
      den_q[s] <= den_s;
      quo_q[s] <= {quo_s[FracBits-2:0], ge};
      tag_q[s] <= tag_s;
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign quot_o  = quo_q[Stages-1];
  assign tag_o   = tag_q[Stages-1];
endmodule

// ===== design/segment_box_intersection.sv =====
// Top level: streaming segment versus axis-aligned box intersection pipeline.
`timescale 1ns / 1ps
// One query is taken every clock cycle (busy is always low) and gives one
// result, strobed on done_o once it has passed the stage 0 and stage 1
// registers, the per-face dividers (one quotient bit per stage) and stages
// M, P and O. Results come out in query order and cannot be held
// off, so the receiver must take each one in the cycle it is shown.
module segment_box_intersection import sbi_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  sbi_query_t  query_i,
  output logic        done_o,
  output sbi_result_t result_o
);
  localparam int unsigned DW   = CoordW + 1;
  localparam int unsigned FB   = COORD_FRAC_BITS;
  localparam int unsigned ProdW = DW + FB + 1;

  assign busy = 1'b0;

  // ---- stage 0: register query, compute reject / inside / face diffs ----
  logic              v0_q;
  logic signed [CoordW-1:0] lo0_q [3];
  logic signed [CoordW-1:0] hi0_q [3];
  logic signed [CoordW-1:0] p10_q [3];
  logic signed [CoordW-1:0] p20_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else         v0_q <= start;
  end

  always_ff @(posedge clk_i) begin
    lo0_q[0] <= query_i.box_min_x; lo0_q[1] <= query_i.box_min_y;
    lo0_q[2] <= query_i.box_min_z;
    hi0_q[0] <= query_i.box_max_x; hi0_q[1] <= query_i.box_max_y;
    hi0_q[2] <= query_i.box_max_z;
    p10_q[0] <= query_i.seg_start_x; p10_q[1] <= query_i.seg_start_y;
    p10_q[2] <= query_i.seg_start_z;
    p20_q[0] <= query_i.seg_end_x; p20_q[1] <= query_i.seg_end_y;
    p20_q[2] <= query_i.seg_end_z;
  end

  logic reject0, inside0;
  logic [NumFaces-1:0] cross0;
  logic [NumFaces-1:0][DW-1:0] num0, den0;

  always_comb begin
    logic signed [DW-1:0] d1, d2, pl;
    logic [DW-1:0] m1, m2;
    int a;
    reject0 = 1'b0;
    inside0 = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if ((p10_q[k] < lo0_q[k] && p20_q[k] < lo0_q[k]) ||
          (p10_q[k] > hi0_q[k] && p20_q[k] > hi0_q[k])) reject0 = 1'b1;
      if (!(p10_q[k] > lo0_q[k] && p10_q[k] < hi0_q[k])) inside0 = 1'b0;
    end
    for (int f = 0; f < NumFaces; f++) begin
      a  = f % 3;
      pl = (f < 3) ? DW'(lo0_q[a]) : DW'(hi0_q[a]);
      d1 = DW'(p10_q[a]) - pl;
      d2 = DW'(p20_q[a]) - pl;
      m1 = d1[DW-1] ? DW'(-d1) : DW'(d1);
      m2 = d2[DW-1] ? DW'(-d2) : DW'(d2);
      cross0[f] = (d1 != '0) && (d2 != '0) && (d1[DW-1] != d2[DW-1]);
      num0[f] = m1;
      // sum < 2^33 since opposite signs keep |d1|+|d2| = |p2-p1| < 2^32
      den0[f] = DW'(m1 + m2);
    end
  end

  // ---- stage 1: registered divider inputs ----
  logic v1_q, rej1_q, in1_q;
  logic [NumFaces-1:0] cr1_q;
  logic [NumFaces-1:0][DW-1:0] num1_q, den1_q;
  logic signed [CoordW-1:0] lo1_q [3];
  logic signed [CoordW-1:0] hi1_q [3];
  logic signed [CoordW-1:0] p11_q [3];
  logic signed [CoordW-1:0] p21_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    rej1_q <= reject0; in1_q <= inside0; cr1_q <= cross0;
    num1_q <= num0; den1_q <= den0;
    lo1_q <= lo0_q; hi1_q <= hi0_q; p11_q <= p10_q; p21_q <= p20_q;
  end

  // ---- dividers, one per face; tag carries the face's crossing flag ----
  logic [NumFaces-1:0]         dv;
  logic [NumFaces-1:0]         dcr;
  logic [NumFaces-1:0][FB-1:0] tq;

  for (genvar f = 0; f < NumFaces; f++) begin : g_div
    sbi_divider #(.FracBits(FB), .DenW(DW), .TagW(1)) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v1_q),
      .num_i   (num1_q[f]),
      .den_i   (cr1_q[f] ? den1_q[f] : DW'(1)),
      .tag_i   (cr1_q[f]),
      .valid_o (dv[f]),
      .quot_o  (tq[f]),
      .tag_o   (dcr[f])
    );
  end

  // side data delay line matching divider latency
  localparam int unsigned Lat = FB;
  typedef struct packed {
    logic rej;
    logic in_box;
    logic [2:0][CoordW-1:0] lo, hi, p1, p2;
  } side_t;

  side_t side_in;
  side_t side_q [Lat];
  always_comb begin
    side_in.rej = rej1_q; side_in.in_box = in1_q;
    for (int k = 0; k < 3; k++) begin
      side_in.lo[k] = lo1_q[k]; side_in.hi[k] = hi1_q[k];
      side_in.p1[k] = p11_q[k]; side_in.p2[k] = p21_q[k];
    end
  end
  always_ff @(posedge clk_i) begin
    side_q[0] <= side_in;
    for (int i = 1; i < Lat; i++) side_q[i] <= side_q[i-1];
  end
  side_t sd;
  assign sd = side_q[Lat-1];

  // ---- stage M: products delta*t per face and axis ----
  logic vm_q;
  side_t sm_q;
  logic [NumFaces-1:0] crm_q;
  logic signed [ProdW-1:0] prod_q [NumFaces][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm_q <= 1'b0;
    else         vm_q <= dv[0];
  end

  always_ff @(posedge clk_i) begin
    logic signed [ProdW-1:0] delta;
    sm_q  <= sd;
    crm_q <= dcr;
    for (int k = 0; k < 3; k++) begin
      delta = ProdW'(signed'(sd.p2[k])) - ProdW'(signed'(sd.p1[k]));
      for (int f = 0; f < NumFaces; f++)
        prod_q[f][k] <= delta * ProdW'(signed'({1'b0, tq[f]}));
    end
  end

  // ---- stage P: points and inside tests per face ----
  logic vp_q;
  side_t sp_q;
  logic signed [CoordW-1:0] pt_q [NumFaces][3];
  logic [NumFaces-1:0] ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vp_q <= 1'b0;
    else         vp_q <= vm_q;
  end

  always_ff @(posedge clk_i) begin
    logic signed [CoordW-1:0] pt [3];
    int b, c;
    sp_q <= sm_q;
    for (int f = 0; f < NumFaces; f++) begin
      b = (f % 3 + 1) % 3;
      c = (f % 3 + 2) % 3;
      for (int k = 0; k < 3; k++) begin
        // arithmetic shift floors, giving floor division by 2^FB
        pt[k] = CoordW'(signed'(sm_q.p1[k]) + (prod_q[f][k] >>> FB));
        pt_q[f][k] <= pt[k];
      end
      ok_q[f] <= crm_q[f] &&
                 pt[b] > signed'(sm_q.lo[b]) && pt[b] < signed'(sm_q.hi[b]) &&
                 pt[c] > signed'(sm_q.lo[c]) && pt[c] < signed'(sm_q.hi[c]);
    end
  end

  // ---- stage O: select inside point or lowest-index hit face, output register ----
  sbi_result_t res_d, res_q;
  logic done_q;

  always_comb begin
    res_d = '0;
    if (!sp_q.rej) begin
      if (sp_q.in_box) begin
        res_d.hit_found = 1'b1;
        res_d.hit_x = sp_q.p1[0]; res_d.hit_y = sp_q.p1[1]; res_d.hit_z = sp_q.p1[2];
      end else begin
        for (int f = NumFaces - 1; f >= 0; f--) begin
          if (ok_q[f]) begin
            res_d.hit_found = 1'b1;
            res_d.hit_x = pt_q[f][0]; res_d.hit_y = pt_q[f][1];
            res_d.hit_z = pt_q[f][2];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= vp_q;
  end
  always_ff @(posedge clk_i) res_q <= res_d;

  assign done_o   = done_q;
  assign result_o = res_q;

  // a miss reports a zero point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.hit_found |-> result_o.hit_x == '0 &&
    result_o.hit_y == '0 && result_o.hit_z == '0)
    else $error("miss with nonzero point");
  // a rejected query never hits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vp_q && sp_q.rej |=> !result_o.hit_found)
    else $error("rejected query reported a hit");
  // divider valid lanes: fails only when exactly one lane is valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(dv) == 1'b0 || dv == '0 || dv == '1)
    else $error("divider lanes out of step");
endmodule
